@@ design/hclp_pkg.sv @@
`default_nettype none
package hclp_pkg;

  localparam int LINE_LEN = 7;
  localparam int COUNT_W  = 3;

  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_DEL  = 8'd127;
  localparam logic [7:0] CH_HASH = 8'd35;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_UA   = 8'd65;
  localparam logic [7:0] CH_UF   = 8'd70;

  typedef logic [7:0] char_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LINE_LEN-1:0][7:0] line_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } line_op_t;

  typedef struct packed {
    line_op_t op;
    char_t    ch;
  } line_act_t;

  typedef struct packed {
    logic  echo_valid;
    char_t echo_byte;
    logic  erase_echo;
    logic  color_valid;
    logic  parse_error;
    char_t red;
    char_t green;
    char_t blue;
  } result_t;

  // Bit 4 flags a legal digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input char_t c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = {1'b1, c[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

@@ design/hex_color_line_parser_core.sv @@
// Line parser for "#RRGGBB" color commands typed over a serial link. Each beat on the input
// channel carries one received byte and produces exactly one beat on the result channel:
// an echo of a stored character, an erase flag for a delete (127), no flag for an ignored byte,
// or on carriage return either the parsed red/green/blue bytes or a parse error, after which
// the line is emptied. Only upper-case hex digits are accepted, and at most seven characters
// are held. Bytes are taken one per clock while the result side keeps up; a byte is held in
// the input register and its result is then written to the output register once that one is
// empty or being drained. The line store is updated as a byte moves into the result register,
// which is what keeps successive bytes in order at full rate.
`default_nettype none
module hex_color_line_parser_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_echo_valid,
  output logic [7:0]      out_echo_byte,
  output logic            out_erase_echo,
  output logic            out_color_valid,
  output logic            out_parse_error,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);

  logic                s1_valid_r;
  hclp_pkg::char_t     s1_byte_r;
  logic                res_valid_r;
  hclp_pkg::result_t   res_r;
  logic                advance;
  hclp_pkg::line_t     line;
  hclp_pkg::count_t    count;
  hclp_pkg::result_t   res_nxt;
  hclp_pkg::line_act_t act;

  // A byte moves on whenever the result register is empty or being drained.
  assign advance  = s1_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  hclp_line_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .act   (act),
    .line  (line),
    .count (count)
  );

  hclp_decode u_decode (
    .rx_byte (s1_byte_r),
    .line    (line),
    .count   (count),
    .res     (res_nxt),
    .act     (act)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_echo_valid  = res_r.echo_valid;
  assign out_echo_byte   = res_r.echo_byte;
  assign out_erase_echo  = res_r.erase_echo;
  assign out_color_valid = res_r.color_valid;
  assign out_parse_error = res_r.parse_error;
  assign out_red         = res_r.red;
  assign out_green       = res_r.green;
  assign out_blue        = res_r.blue;

endmodule
`default_nettype wire

@@ design/hclp_line_store.sv @@
`default_nettype none
module hclp_line_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire hclp_pkg::line_act_t act,
  output hclp_pkg::line_t        line,
  output hclp_pkg::count_t       count
);

  hclp_pkg::line_t  store_r, store_nxt;
  hclp_pkg::count_t count_r, count_nxt;

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    unique case (act.op)
      hclp_pkg::OP_PUSH: begin
        for (int i = 0; i < hclp_pkg::LINE_LEN; i++) begin
          if (count_r == hclp_pkg::COUNT_W'(i)) begin
            store_nxt[i] = act.ch;
          end
        end
        count_nxt = count_r + hclp_pkg::COUNT_W'(1);
      end
      hclp_pkg::OP_POP: begin
        count_nxt = count_r - hclp_pkg::COUNT_W'(1);
        // Entries at or above the count are kept at zero.
        for (int i = 0; i < hclp_pkg::LINE_LEN; i++) begin
          if (count_nxt == hclp_pkg::COUNT_W'(i)) begin
            store_nxt[i] = 8'd0;
          end
        end
      end
      hclp_pkg::OP_CLEAR: begin
        store_nxt = '0;
        count_nxt = '0;
      end
      hclp_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      count_r <= '0;
    end else if (en) begin
      store_r <= store_nxt;
      count_r <= count_nxt;
    end
  end

  assign line  = store_r;
  assign count = count_r;

endmodule
`default_nettype wire

@@ design/hclp_decode.sv @@
`default_nettype none
module hclp_decode (
  input  wire hclp_pkg::char_t   rx_byte,
  input  wire hclp_pkg::line_t   line,
  input  wire hclp_pkg::count_t  count,
  output hclp_pkg::result_t      res,
  output hclp_pkg::line_act_t    act
);

  logic [5:0][4:0] dig;
  logic            well_formed;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dig[k] = hclp_pkg::hex_digit(line[k+1]);
    end
    well_formed = (line[0] == hclp_pkg::CH_HASH);
    for (int k = 0; k < 6; k++) begin
      well_formed = well_formed & dig[k][4];
    end
  end

  always_comb begin
    res    = '0;
    act.op = hclp_pkg::OP_NONE;
    act.ch = rx_byte;
    priority if (rx_byte == hclp_pkg::CH_CR) begin
      act.op = hclp_pkg::OP_CLEAR;
      if (well_formed) begin
        res.color_valid = 1'b1;
        res.red   = {dig[0][3:0], dig[1][3:0]};
        res.green = {dig[2][3:0], dig[3][3:0]};
        res.blue  = {dig[4][3:0], dig[5][3:0]};
      end else begin
        res.parse_error = 1'b1;
      end
    end else if (rx_byte == hclp_pkg::CH_DEL) begin
      if (count != '0) begin
        act.op         = hclp_pkg::OP_POP;
        res.erase_echo = 1'b1;
      end
    end else if (count < hclp_pkg::COUNT_W'(hclp_pkg::LINE_LEN)) begin
      act.op         = hclp_pkg::OP_PUSH;
      res.echo_valid = 1'b1;
      res.echo_byte  = rx_byte;
    end else begin
      // A full line ignores any further ordinary byte.
    end
  end

endmodule
`default_nettype wire

@@ design/hclp_checker.sv @@
`default_nettype none
module hclp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_echo_valid,
  input wire logic [7:0] out_echo_byte,
  input wire logic       out_erase_echo,
  input wire logic       out_color_valid,
  input wire logic       out_parse_error,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // A stalled result beat holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_echo_valid, out_echo_byte, out_erase_echo, out_color_valid,
               out_parse_error, out_red, out_green, out_blue}))
    else $error("result beat changed while stalled");

  // The input side only waits on a full result register.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with result register empty");

  // An accepted byte taken while no result is held reaches the result side.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |-> ##2 out_valid)
    else $error("accepted beat did not produce a result");

  // At most one kind of event per result beat.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_echo_valid, out_erase_echo, out_color_valid,
                              out_parse_error}) <= 1)
    else $error("result beat flags more than one event");

endmodule

bind hex_color_line_parser_core hclp_checker u_hclp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_echo_valid  (out_echo_valid),
  .out_echo_byte   (out_echo_byte),
  .out_erase_echo  (out_erase_echo),
  .out_color_valid (out_color_valid),
  .out_parse_error (out_parse_error),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue)
);
`default_nettype wire

@@ sim/hex_color_line_parser_checker.sv @@
`default_nettype none
module hex_color_line_parser_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       out_echo_valid,
  input  wire logic [7:0] out_echo_byte,
  input  wire logic       out_erase_echo,
  input  wire logic       out_color_valid,
  input  wire logic       out_parse_error,
  input  wire logic [7:0] out_red,
  input  wire logic [7:0] out_green,
  input  wire logic [7:0] out_blue,
  output int              mismatch_count,
  output int              results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  hclp_pkg::char_t   held_chars [hclp_pkg::LINE_LEN];
  int                held_count;
  hclp_pkg::result_t awaited_results [$];
  int                fails;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    fails           = 0;
    held_count      = 0;
    held_chars      = '{default: '0};
  end

  // Bit 4 set means the character is not an upper-case hex digit.
  function automatic logic [4:0] nibble_of(input hclp_pkg::char_t c);
    if (c >= hclp_pkg::CH_ZERO && c <= hclp_pkg::CH_NINE) begin
      return {1'b0, 4'(c - hclp_pkg::CH_ZERO)};
    end else if (c >= hclp_pkg::CH_UA && c <= hclp_pkg::CH_UF) begin
      return {1'b0, 4'(c - hclp_pkg::CH_UA + 8'd10)};
    end
    return 5'h10;
  endfunction

  // Applies one received byte to the held line and returns the beat it should produce.
  function automatic hclp_pkg::result_t line_response(input hclp_pkg::char_t c);
    hclp_pkg::result_t r;
    logic              well_formed;
    logic [4:0]        nib [6];
    int                k;
    r = '0;
    if (c == hclp_pkg::CH_CR) begin
      well_formed = (held_chars[0] == hclp_pkg::CH_HASH);
      for (k = 0; k < 6; k++) begin
        nib[k] = nibble_of(held_chars[k + 1]);
        if (nib[k][4]) begin
          well_formed = 1'b0;
        end
      end
      if (well_formed) begin
        r.color_valid = 1'b1;
        r.red         = {nib[0][3:0], nib[1][3:0]};
        r.green       = {nib[2][3:0], nib[3][3:0]};
        r.blue        = {nib[4][3:0], nib[5][3:0]};
      end else begin
        r.parse_error = 1'b1;
      end
      held_chars = '{default: '0};
      held_count = 0;
    end else if (c == hclp_pkg::CH_DEL) begin
      if (held_count > 0) begin
        held_count--;
        held_chars[held_count] = '0;
        r.erase_echo = 1'b1;
      end
    end else if (held_count < hclp_pkg::LINE_LEN) begin
      held_chars[held_count] = c;
      held_count++;
      r.echo_valid = 1'b1;
      r.echo_byte  = c;
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    hclp_pkg::result_t due;
    if (!rst_n) begin
      held_chars = '{default: '0};
      held_count = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(line_response(in_rx_byte));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          fails++;
        end else begin
          due = awaited_results.pop_front();
          compare_field("echo_valid", 8'(due.echo_valid), 8'(out_echo_valid));
          compare_field("echo_byte", due.echo_byte, out_echo_byte);
          compare_field("erase_echo", 8'(due.erase_echo), 8'(out_erase_echo));
          compare_field("color_valid", 8'(due.color_valid), 8'(out_color_valid));
          compare_field("parse_error", 8'(due.parse_error), 8'(out_parse_error));
          compare_field("red", due.red, out_red);
          compare_field("green", due.green, out_green);
          compare_field("blue", due.blue, out_blue);
        end
      end
    end
    mismatch_count  <= fails;
    results_pending <= awaited_results.size();
  end

endmodule
`default_nettype wire

@@ sim/hex_color_line_parser_core_tb.sv @@
`default_nettype none
module hex_color_line_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 500;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_echo_valid;
  logic [7:0] out_echo_byte;
  logic       out_erase_echo;
  logic       out_color_valid;
  logic       out_parse_error;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  int         mismatch_count;
  int         results_pending;

  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    bytes_sent = 0;
  int    cycle_count = 0;
  string hex_chars = "0123456789ABCDEF";
  string near_misses = "/:@G`g";

  hex_color_line_parser_core u_dut (.*);

  hex_color_line_parser_checker u_checker (.*);

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hex_color_line_parser_core regression: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input hclp_pkg::char_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  initial begin : stimulus
    int              phase;
    int              kind;
    int              len;
    int              pick;
    int              k;
    hclp_pkg::char_t c;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          stall_pct     = 46;
        end
        1: begin
          send_idle_pct = 46;
          stall_pct     = 7;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      if (phase == 0) begin
        // Delete on an empty line, then an empty line closed.
        send_byte(hclp_pkg::CH_DEL);
        send_byte(hclp_pkg::CH_CR);
        // A NUL fills the line, a further byte is ignored, and the NUL fails the check.
        send_text("#FFFFF");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hclp_pkg::CH_CR);
        // A lower-case digit is erased and retyped before a good code is closed.
        send_text("#90AFEa");
        send_byte(hclp_pkg::CH_DEL);
        send_text("9");
        send_byte(hclp_pkg::CH_CR);
      end
      while (bytes_sent < (phase + 1) * PHASE_BYTES) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          send_byte(hclp_pkg::CH_HASH);
          for (k = 0; k < 6; k++) begin
            if ($urandom_range(9) == 0) begin
              send_byte(8'($urandom_range(255)));
              send_byte(hclp_pkg::CH_DEL);
            end
            send_byte(hex_chars[$urandom_range(15)]);
          end
          if ($urandom_range(6) == 0) begin
            send_byte(8'($urandom_range(255)));
          end
          send_byte(hclp_pkg::CH_CR);
        end else if (kind < 85) begin
          len = $urandom_range(9);
          for (k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (k == 0 && pick < 70) begin
              c = hclp_pkg::CH_HASH;
            end else if (pick < 50) begin
              c = hex_chars[$urandom_range(15)];
            end else if (pick < 62) begin
              c = 8'("a") + 8'($urandom_range(5));
            end else if (pick < 74) begin
              c = near_misses[$urandom_range(near_misses.len() - 1)];
            end else begin
              c = 8'($urandom_range(255));
            end
            send_byte(c);
          end
          send_byte(hclp_pkg::CH_CR);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(2) == 0) begin
              send_byte(hclp_pkg::CH_DEL);
            end else begin
              send_byte(8'($urandom_range(255)));
            end
          end
        end
      end
    end
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("hex_color_line_parser_core regression: pass");
    end else begin
      $display("hex_color_line_parser_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
design/hclp_pkg.sv
design/hclp_line_store.sv
design/hclp_decode.sv
design/hex_color_line_parser_core.sv
design/hclp_checker.sv
sim/hex_color_line_parser_checker.sv
sim/hex_color_line_parser_core_tb.sv
